// ===== rtl/irpd_pkg.sv =====
// Shared types and constants for the IR reflectance pair detector.
// Holds field widths, register reset values and register index codes.
// No dependencies.
package irpd_pkg;

  // Field widths
  localparam int ADC_W = 11;
  localparam int THR_W = 11;
  localparam int CNT_W = 8;

  // Defaults
  localparam int SAMPLES_PER_BLOCK_DEF = 10;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 11'd180;
  localparam logic [CNT_W-1:0] CONFIRM_RST   = 8'd10;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_CONFIRM   = 1'b1
  } reg_idx_t;

endpackage

// ===== rtl/ir_reflect_pair_detector_top.sv =====
// IR reflectance pair detector: block averaging, on/off compare, hit counting.
// Depends on irpd_pkg (widths, reset values, register codes).
//
// Usage:
//   Input channel (in_valid/in_ready, in_adc_sample) carries one converter
//   sample per transaction. Samples form blocks of SAMPLES_PER_BLOCK; the first
//   sample of each block is dropped and the rest are averaged (truncated toward
//   zero). Blocks alternate IR-off / IR-on, starting with IR off.
//   Output channel (out_valid/out_ready) carries one transaction per finished
//   block: average, phase, detection flag, LED drive for the next block and
//   the consecutive-hit count.
//   Configuration port (APB style, pready tied high): register 0 at byte 0 is
//   detect_threshold, register 1 at byte 4 is confirm_count.
// Throughput: one sample per cycle, sustained unless a held result stalls the
//   last sample of a block; set by the single accumulate stage. The divide is
//   a constant reciprocal multiply in its own stage. A block's last sample
//   passes the input register, the final-sum register and the result register
//   in that order.
// Reset: rst_n (synchronous, active low) empties the pipeline, clears the
//   sample index, sum, stored off average, phase (IR off), hit counter and
//   detection flag, and loads the register defaults.
// Stall: while out_ready is low a finished result is held; samples of the next
//   block keep flowing until its last sample needs the occupied stages.
module ir_reflect_pair_detector_top #(
  parameter int SAMPLES_PER_BLOCK = irpd_pkg::SAMPLES_PER_BLOCK_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [irpd_pkg::ADC_W-1:0]  in_adc_sample,
  // Output channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [irpd_pkg::ADC_W-1:0]  out_block_average,
  output logic                               out_phase_on,
  output logic                               out_object_detected,
  output logic                               out_ir_led_on,
  output logic        [irpd_pkg::CNT_W-1:0]  out_hit_count,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic        [irpd_pkg::CFG_AW-1:0] paddr,
  input  logic        [irpd_pkg::CFG_DW-1:0] pwdata,
  output logic        [irpd_pkg::CFG_DW-1:0] prdata,
  output logic                               pready
);
  import irpd_pkg::*;

  // Derived sizes
  localparam int IDX_W  = (SAMPLES_PER_BLOCK > 2) ? $clog2(SAMPLES_PER_BLOCK) : 1;
  localparam int SUM_W  = ADC_W + IDX_W;
  localparam int DIV    = (SAMPLES_PER_BLOCK > 1) ? SAMPLES_PER_BLOCK - 1 : 1;
  localparam int SH_L   = $clog2(DIV);
  localparam int SH     = SUM_W + SH_L;
  localparam int M_W    = SUM_W + 1;
  localparam int PROD_W = SUM_W + M_W;
  localparam logic [63:0] MULT_FULL = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [M_W-1:0]   MULT     = MULT_FULL[M_W-1:0];
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_BLOCK - 1);

  // Configuration registers
  logic [THR_W-1:0] thr_r;
  logic [CNT_W-1:0] confirm_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESHOLD_RST;
      confirm_r <= CONFIRM_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_THRESHOLD: thr_r     <= pwdata[THR_W-1:0];
        REG_CONFIRM:   confirm_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_THRESHOLD: prdata = CFG_DW'(thr_r);
      REG_CONFIRM:   prdata = CFG_DW'(confirm_r);
      default:       prdata = '0;
    endcase
  end

  // Pipeline registers
  logic                    s1_vld_r;
  logic signed [ADC_W-1:0] smp_r;
  logic [IDX_W-1:0]        idx_r;
  logic signed [SUM_W-1:0] sum_r;
  logic                    s2_vld_r;
  logic signed [SUM_W-1:0] fsum_r;
  logic                    out_vld_r;

  // Detector state
  logic                    phase_r;
  logic signed [ADC_W-1:0] off_avg_r;
  logic [CNT_W-1:0]        hits_r;
  logic                    det_r;

  // Result registers
  logic signed [ADC_W-1:0] avg_out_r;
  logic                    phase_out_r;

  // Stage handshakes: each stage moves when the one after it has room
  logic out_free, s2_rdy, s1_last, s1_take, s2_take;
  logic signed [SUM_W-1:0] sum_add;

  assign out_free = !out_vld_r || out_ready;
  assign s2_rdy   = !s2_vld_r || out_free;
  assign s2_take  = s2_vld_r && out_free;
  assign s1_last  = (idx_r == LAST_IDX);
  assign s1_take  = s1_vld_r && (!s1_last || s2_rdy);
  assign in_ready = !s1_vld_r || s1_take;
  assign sum_add  = sum_r + SUM_W'(smp_r);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r <= in_adc_sample;
    end
  end

  // Accumulate; drop the first sample of a block, hand off the sum at its end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      sum_r    <= '0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s2_take) begin
        s2_vld_r <= 1'b0;
      end
      if (s1_take) begin
        if (s1_last) begin
          idx_r    <= '0;
          sum_r    <= '0;
          s2_vld_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
          if (idx_r != '0) begin
            sum_r <= sum_add;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_last) begin
      fsum_r <= (idx_r != '0) ? sum_add : sum_r;
    end
  end

  // Divide by block length minus one: reciprocal multiply on the magnitude
  logic                    neg;
  logic [SUM_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [ADC_W-1:0]        quo;
  logic signed [ADC_W-1:0] avg;

  assign neg  = fsum_r[SUM_W-1];
  assign mag  = neg ? SUM_W'(-fsum_r) : SUM_W'(fsum_r);
  assign prod = PROD_W'(mag) * PROD_W'(MULT);
  assign quo  = ADC_W'(prod >> SH);
  assign avg  = neg ? $signed(-quo) : $signed(quo);

  // Compare on minus off against threshold, update the hit counter
  logic signed [ADC_W+1:0] diff;
  logic                    hit;
  logic [CNT_W:0]          hits_c;
  logic                    sat;
  logic [CNT_W-1:0]        hits_nxt;

  assign diff     = (ADC_W+2)'(avg) - (ADC_W+2)'(off_avg_r);
  assign hit      = diff > $signed({2'b00, thr_r});
  assign hits_c   = hit ? ({1'b0, hits_r} + 1'b1) : '0;
  assign sat      = hits_c >= {1'b0, confirm_r};
  assign hits_nxt = sat ? confirm_r : hits_c[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      phase_r   <= 1'b0;
      off_avg_r <= '0;
      hits_r    <= '0;
      det_r     <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_r <= s2_vld_r;
      end
      if (s2_take) begin
        phase_r <= !phase_r;
        if (!phase_r) begin
          off_avg_r <= avg;
        end else begin
          hits_r <= hits_nxt;
          det_r  <= sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      avg_out_r   <= avg;
      phase_out_r <= phase_r;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_block_average   = avg_out_r;
  assign out_phase_on        = phase_out_r;
  assign out_object_detected = det_r;
  assign out_ir_led_on       = phase_r;
  assign out_hit_count       = hits_r;

`ifndef SYNTH
  // LED drive for the next block is always the opposite of the finished phase
  a_led_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_ir_led_on != out_phase_on))
    else $error("LED drive does not follow the phase toggle");

  // Sample index never passes the last slot of a block
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("sample index out of range");

  // A finished sum arrives only together with the index wrapping to zero
  a_sum_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s2_vld_r) |-> (idx_r == '0) && (sum_r == '0))
    else $error("block sum handed off without index wrap");

  // Input back-pressure only when the input register holds a stuck sample
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_vld_r && s1_last && s2_vld_r && out_vld_r)
    else $error("input stalled without a full pipeline");
`endif

endmodule
